@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define MCK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well
`define MCK_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mck_pkg.sv @@
// ----------------------------------------------------------------------------
// mck_pkg
// Types, Morse tables and character classification for the Morse keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int TABLE_SIZE = 38;

  // Character codes
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  localparam logic [5:0] DIGIT_BASE   = 6'd26;
  localparam logic [5:0] COMMA_INDEX  = 6'd36;
  localparam logic [5:0] PERIOD_INDEX = 6'd37;

  // Item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  // Phase lengths in units
  localparam logic [3:0] DOT_UNITS    = 4'd1;
  localparam logic [3:0] DASH_UNITS   = 4'd3;
  localparam logic [3:0] SPACE_UNITS  = 4'd1;
  localparam logic [3:0] LETTER_UNITS = 4'd3;
  localparam logic [3:0] WORD_UNITS   = 4'd7;

  localparam logic [15:0] UNIT_TICKS_RST = 16'd200;

  // Symbol bits (1 = dash, bit 0 first) and symbol counts
  localparam logic [5:0] MORSE_BITS [TABLE_SIZE] = '{
    6'h02, 6'h01, 6'h05, 6'h01, 6'h00, 6'h04, 6'h03, 6'h00, 6'h00, 6'h0E,
    6'h05, 6'h02, 6'h03, 6'h01, 6'h07, 6'h06, 6'h0B, 6'h02, 6'h00, 6'h01,
    6'h04, 6'h08, 6'h06, 6'h09, 6'h0D, 6'h03,
    6'h1F, 6'h1E, 6'h1C, 6'h18, 6'h10, 6'h00, 6'h01, 6'h03, 6'h07, 6'h0F,
    6'h33, 6'h2A
  };

  localparam logic [2:0] MORSE_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd6, 3'd6
  };

  // Classified item carried from front to back
  typedef struct packed {
    logic       cmd;
    logic       known;
    logic       ends_word;
    logic [5:0] pattern;
    logic [2:0] count;
  } mck_item_t;

  // Look up a character and build a queue entry
  function automatic mck_item_t mck_classify(input logic cmd, input logic [7:0] ch,
                                             input logic ends_word);
    mck_item_t  item;
    logic [7:0] c;
    logic [7:0] diff;
    logic [5:0] idx;
    logic       known;
    c     = ch;
    idx   = '0;
    known = 1'b0;
    diff  = '0;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      c = c - CASE_DELTA;
    end
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      diff  = c - CHAR_UC_A;
      idx   = diff[5:0];
      known = 1'b1;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff  = c - CHAR_ZERO;
      idx   = diff[5:0] + DIGIT_BASE;
      known = 1'b1;
    end else if (c == CHAR_COMMA) begin
      idx   = COMMA_INDEX;
      known = 1'b1;
    end else if (c == CHAR_DOT) begin
      idx   = PERIOD_INDEX;
      known = 1'b1;
    end
    item.cmd       = cmd;
    item.known     = known;
    item.ends_word = ends_word;
    item.pattern   = known ? MORSE_BITS[idx] : 6'd0;
    item.count     = known ? MORSE_LEN[idx] : 3'd0;
    return item;
  endfunction

endpackage

@@ rtl/mck_if.sv @@
// ----------------------------------------------------------------------------
// Keyer channel interfaces
// Valid/ready channels for item beats in and result beats out.
// ----------------------------------------------------------------------------
interface mck_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;
  logic       ends_word;

  modport source (output valid, cmd, char_code, ends_word, input ready);
  modport sink   (input valid, cmd, char_code, ends_word, output ready);
endinterface

interface mck_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic accepted;
  logic bad_char;

  modport source (output valid, led_on, busy_res, accepted, bad_char, input ready);
  modport sink   (input valid, led_on, busy_res, accepted, bad_char, output ready);
endinterface

@@ rtl/morse_code_keyer_top.sv @@
// ----------------------------------------------------------------------------
// morse_code_keyer_top
// Morse keyer: characters are looked up and keyed onto an LED level,
// timed by tick beats.
// ----------------------------------------------------------------------------
//   channel | dir | handshake        | payload
//   in_bus  | in  | valid/ready      | cmd, char_code, ends_word
//   out_bus | out | valid/ready      | led_on, busy_res, accepted, bad_char
//   cfg     | in  | cfg_we (no wait) | cfg_wdata = unit_ticks
//
// One beat per cycle on each side while neither side stalls; each input beat
// gives one result beat, registered first by the queue write and then by the
// back part's output register. The back part's state update sets the rate.
// Synchronous reset clears the queue, the keyer state and the output valid.
// A stalled output holds its beat; the queue (QUEUE_DEPTH beats) absorbs
// input until full, then in_bus.ready drops.
// ----------------------------------------------------------------------------
module morse_code_keyer_top #(
  parameter int TICK_COUNT_WIDTH = 16,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  mck_in_if.sink       in_bus,
  mck_out_if.source    out_bus,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import mck_pkg::*;

  localparam int ITEM_W = $bits(mck_item_t);

  logic      q_full, q_push, q_pop, q_valid;
  mck_item_t push_item, head_item;

  // Front: accept and classify
  mck_front u_front (
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_cmd       (in_bus.cmd),
    .in_char_code (in_bus.char_code),
    .in_ends_word (in_bus.ends_word),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // Queue between front and back
  mck_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (head_item)
  );

  // Back: timing engine and result register
  mck_back #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_led_on   (out_bus.led_on),
    .out_busy_res (out_bus.busy_res),
    .out_accepted (out_bus.accepted),
    .out_bad_char (out_bus.bad_char)
  );

endmodule

@@ rtl/mck_front.sv @@
// ----------------------------------------------------------------------------
// mck_front
// Accepts item beats, classifies characters through the Morse table and
// pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mck_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_char_code,
  input  logic              in_ends_word,
  input  logic              q_full,
  output logic              q_push,
  output mck_pkg::mck_item_t q_item
);
  import mck_pkg::*;

  // Take a beat whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Table lookup, done once per beat
  assign q_item = mck_classify(in_cmd, in_char_code, in_ends_word);

endmodule

@@ rtl/mck_fifo.sv @@
// ----------------------------------------------------------------------------
// mck_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mck_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/mck_back.sv @@
// ----------------------------------------------------------------------------
// mck_back
// Keyer timing engine: runs the phase machine on ticks, starts letters on
// offers and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module mck_back #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               q_valid,
  input  mck_pkg::mck_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_led_on,
  output logic               out_busy_res,
  output logic               out_accepted,
  output logic               out_bad_char
);
  import mck_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CW = (TW > 16) ? TW : 16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MARK,
    PH_SPACE,
    PH_LGAP,
    PH_WGAP
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [5:0]    pattern_r, pattern_nxt;
  logic [2:0]    count_r, count_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [3:0]    units_r, units_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic          wgap_r, wgap_nxt;
  logic [15:0]   unit_ticks_r;

  logic          out_valid_r, out_valid_nxt;
  logic          led_r, busy_r, acc_r, bad_r;
  logic          acc_nxt, bad_nxt;

  logic [TW-1:0] tick_inc;
  logic [15:0]   limit;
  logic          unit_done;
  logic [3:0]    units_dec;
  logic [2:0]    pos_inc;
  logic [7:0]    pattern_ext;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Unit boundary detection
  assign tick_inc    = tick_r + 1'b1;
  assign limit       = (unit_ticks_r == '0) ? 16'd1 : unit_ticks_r;
  assign unit_done   = (CW'(tick_inc) >= CW'(limit)) || (tick_inc == {TW{1'b1}});
  assign units_dec   = (units_r != '0) ? units_r - 1'b1 : units_r;
  assign pos_inc     = pos_r + 1'b1;
  assign pattern_ext = {2'b00, pattern_r};

  // Next state for the beat at the queue head
  always_comb begin
    phase_nxt   = phase_r;
    pattern_nxt = pattern_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    units_nxt   = units_r;
    tick_nxt    = tick_r;
    wgap_nxt    = wgap_r;
    acc_nxt     = 1'b0;
    bad_nxt     = 1'b0;
    if (q_item.cmd == CMD_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (!unit_done) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt  = '0;
          units_nxt = units_dec;
          if (units_dec == '0) begin
            // End of the current phase
            case (phase_r)
              PH_MARK: begin
                phase_nxt = PH_SPACE;
                units_nxt = SPACE_UNITS;
              end
              PH_SPACE: begin
                pos_nxt = pos_inc;
                if (pos_inc < count_r) begin
                  phase_nxt = PH_MARK;
                  units_nxt = pattern_ext[pos_inc] ? DASH_UNITS : DOT_UNITS;
                end else begin
                  phase_nxt = PH_LGAP;
                  units_nxt = LETTER_UNITS;
                end
              end
              PH_LGAP: begin
                if (wgap_r) begin
                  wgap_nxt  = 1'b0;
                  phase_nxt = PH_WGAP;
                  units_nxt = WORD_UNITS;
                end else begin
                  phase_nxt = PH_IDLE;
                  units_nxt = '0;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
                units_nxt = '0;
                wgap_nxt  = 1'b0;
              end
            endcase
          end
        end
      end
    end else if (phase_r == PH_IDLE) begin
      // Offer taken while idle: start the letter at once, or a letter gap if unknown
      acc_nxt  = 1'b1;
      tick_nxt = '0;
      pos_nxt  = '0;
      wgap_nxt = q_item.ends_word;
      if (q_item.known) begin
        pattern_nxt = q_item.pattern;
        count_nxt   = q_item.count;
        phase_nxt   = PH_MARK;
        units_nxt   = q_item.pattern[0] ? DASH_UNITS : DOT_UNITS;
      end else begin
        bad_nxt     = 1'b1;
        pattern_nxt = '0;
        count_nxt   = '0;
        phase_nxt   = PH_LGAP;
        units_nxt   = LETTER_UNITS;
      end
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State, configuration and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pattern_r    <= '0;
      count_r      <= '0;
      pos_r        <= '0;
      units_r      <= '0;
      tick_r       <= '0;
      wgap_r       <= 1'b0;
      unit_ticks_r <= UNIT_TICKS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unit_ticks_r <= cfg_wdata;
      end
      if (q_pop) begin
        phase_r   <= phase_nxt;
        pattern_r <= pattern_nxt;
        count_r   <= count_nxt;
        pos_r     <= pos_nxt;
        units_r   <= units_nxt;
        tick_r    <= tick_nxt;
        wgap_r    <= wgap_nxt;
      end
    end
    if (q_pop) begin
      led_r  <= (phase_nxt == PH_MARK);
      busy_r <= (phase_nxt != PH_IDLE);
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_led_on   = led_r;
  assign out_busy_res = busy_r;
  assign out_accepted = acc_r;
  assign out_bad_char = bad_r;

endmodule

@@ rtl/mck_checker.sv @@
// ----------------------------------------------------------------------------
// mck_checker
// Port-level checks on the keyer's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mck_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_led_on,
  input logic out_busy_res,
  input logic out_accepted,
  input logic out_bad_char
);

  // A stalled result beat stays offered
  `MCK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // A taken character always starts timing
  `MCK_ASSERT(a_acc_busy, clk, rst_n, out_valid && out_accepted |-> out_busy_res, "accepted character without busy")

  // An unknown character is flagged only when taken, and keeps the LED dark
  `MCK_ASSERT(a_bad_dark, clk, rst_n, out_valid && out_bad_char |-> out_accepted && !out_led_on, "bad character lit LED or was not taken")

  // A lit LED means a letter is in progress
  `MCK_ASSERT(a_led_busy, clk, rst_n, out_valid && out_led_on |-> out_busy_res, "LED lit while idle")

  // No result beat right after reset
  `MCK_ASSERT_RST(a_rst_quiet, clk, !rst_n |=> !out_valid, "result beat after reset")

endmodule

bind morse_code_keyer_top mck_checker u_mck_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_led_on   (out_bus.led_on),
  .out_busy_res (out_bus.busy_res),
  .out_accepted (out_bus.accepted),
  .out_bad_char (out_bus.bad_char)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse keyer testbench
// A table of directed beats goes first: idle ticks, refused offers, unknown
// and lower-case characters, digits, punctuation, and zero and full-scale unit
// lengths. Random letter sequences follow over several unit lengths. Each
// result beat is checked against a typed value or a keyer model in this file.
// ----------------------------------------------------------------------------
module testbench;
  import mck_pkg::*;

  // Phase lengths in units
  localparam logic [3:0] UNITS_DOT    = 4'd1;
  localparam logic [3:0] UNITS_DASH   = 4'd3;
  localparam logic [3:0] UNITS_SPACE  = 4'd1;
  localparam logic [3:0] UNITS_LETTER = 4'd3;
  localparam logic [3:0] UNITS_WORD   = 4'd7;
  localparam int         PHASE_BEATS  = 250;
  localparam int         HOLD_CYCLES  = 200;

  typedef enum logic [2:0] {
    KEY_IDLE, KEY_MARK, KEY_SPACE, KEY_LGAP, KEY_WGAP
  } key_phase_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic accepted;
    logic bad_char;
  } level_beat_t;

  typedef enum bit {ROW_BEAT, ROW_UNIT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] unit;
    logic        cmd;
    logic [7:0]  ch;
    logic        ew;
    int          reps;
    bit          typed;
    level_beat_t res;    // led, busy, accepted, bad
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  mck_in_if  in_bus ();
  mck_out_if out_bus ();

  morse_code_keyer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Standard Morse, symbol 0 first
  string letter_morse [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_morse [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // Directed beats; typed results only where they are obvious
  script_row_t plan [25] = '{
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 1, 1'b1, 4'b0000},     // tick while idle
    '{ROW_BEAT, 16'd0, CMD_OFFER, "E", 1'b0, 1, 1'b1, 4'b1110},
    '{ROW_BEAT, 16'd0, CMD_OFFER, "T", 1'b0, 1, 1'b1, 4'b1100},      // busy, refused
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'hFF, 1'b1, 199, 1'b1, 4'b1100},   // one short of a unit
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 1, 1'b0, 4'b0000},
    '{ROW_UNIT, 16'd0, CMD_TICK, 8'h00, 1'b0, 0, 1'b0, 4'b0000},     // zero acts as one
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h55, 1'b0, 6, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, 8'hFF, 1'b1, 1, 1'b1, 4'b0111},    // unknown, word end
    '{ROW_BEAT, 16'd0, CMD_OFFER, 8'h00, 1'b0, 1, 1'b1, 4'b0100},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'hAA, 1'b1, 12, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, "z", 1'b1, 1, 1'b1, 4'b1110},      // lower case
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 24, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, "0", 1'b0, 1, 1'b1, 4'b1110},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 24, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, ",", 1'b1, 1, 1'b1, 4'b1110},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 32, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, ".", 1'b0, 1, 1'b1, 4'b1110},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 24, 1'b0, 4'b0000},
    '{ROW_BEAT, 16'd0, CMD_OFFER, 8'h80, 1'b0, 1, 1'b1, 4'b0111},    // above ASCII
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 4, 1'b0, 4'b0000},
    '{ROW_UNIT, 16'hFFFF, CMD_TICK, 8'h00, 1'b0, 0, 1'b0, 4'b0000},  // longest unit
    '{ROW_BEAT, 16'd0, CMD_OFFER, "a", 1'b0, 1, 1'b1, 4'b1110},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 100, 1'b1, 4'b1100},
    '{ROW_BEAT, 16'd0, CMD_TICK, 8'h00, 1'b0, 1, 1'b0, 4'b0000},
    '{ROW_UNIT, 16'd1, CMD_TICK, 8'h00, 1'b0, 0, 1'b0, 4'b0000}
  };

  logic [15:0] phase_unit [5] = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd5};

  // Keyer model state
  key_phase_t  key_phase      = KEY_IDLE;
  logic [3:0]  key_units      = '0;
  logic [15:0] key_ticks      = '0;
  logic        key_word_gap   = 1'b0;
  string       key_code       = "";
  int          key_pos        = 0;
  logic [15:0] key_unit_ticks = UNIT_TICKS_RST;

  level_beat_t pending_levels [$];
  int          level_errors = 0;
  bit          idle_on      = 1'b1;
  bit          hold_request = 1'b0;

  // Morse string of a character, empty when it has none
  function automatic string morse_of(logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "A" && c <= "Z") return letter_morse[c - "A"];
    if (c >= "0" && c <= "9") return digit_morse[c - "0"];
    if (c == ",") return "--..--";
    if (c == ".") return ".-.-.-";
    return "";
  endfunction

  function automatic void begin_symbol();
    key_phase = KEY_MARK;
    key_units = (key_code[key_pos] == "-") ? UNITS_DASH : UNITS_DOT;
  endfunction

  // One beat through the keyer model; returns the level beat it gives
  function automatic level_beat_t keyer_step(logic cmd, logic [7:0] ch, logic ew);
    level_beat_t r;
    logic [16:0] limit;
    r = '0;
    limit = (key_unit_ticks == 16'd0) ? 17'd1 : {1'b0, key_unit_ticks};
    if (cmd == CMD_TICK) begin
      if (key_phase != KEY_IDLE) begin
        key_ticks = key_ticks + 16'd1;
        if ({1'b0, key_ticks} >= limit || key_ticks == 16'hFFFF) begin
          key_ticks = '0;
          if (key_units != 4'd0) key_units = key_units - 4'd1;
          if (key_units == 4'd0) begin
            case (key_phase)
              KEY_MARK: begin
                key_phase = KEY_SPACE;
                key_units = UNITS_SPACE;
              end
              KEY_SPACE: begin
                key_pos = key_pos + 1;
                if (key_pos < key_code.len()) begin
                  begin_symbol();
                end else begin
                  key_phase = KEY_LGAP;
                  key_units = UNITS_LETTER;
                end
              end
              KEY_LGAP: begin
                if (key_word_gap) begin
                  key_word_gap = 1'b0;
                  key_phase    = KEY_WGAP;
                  key_units    = UNITS_WORD;
                end else begin
                  key_phase = KEY_IDLE;
                  key_units = '0;
                end
              end
              default: begin
                key_phase    = KEY_IDLE;
                key_units    = '0;
                key_word_gap = 1'b0;
              end
            endcase
          end
        end
      end
    end else if (key_phase == KEY_IDLE) begin
      r.accepted   = 1'b1;
      key_ticks    = '0;
      key_pos      = 0;
      key_word_gap = ew;
      key_code     = morse_of(ch);
      if (key_code.len() == 0) begin
        r.bad_char = 1'b1;
        key_phase  = KEY_LGAP;
        key_units  = UNITS_LETTER;
      end else begin
        begin_symbol();
      end
    end
    r.led_on   = (key_phase == KEY_MARK);
    r.busy_res = (key_phase != KEY_IDLE);
    return r;
  endfunction

  // Offer one beat with random idle gaps; log its expected level on acceptance
  task automatic drive_beat(logic cmd, logic [7:0] ch, logic ew, bit typed,
                            level_beat_t typed_res);
    level_beat_t r;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 24) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= cmd;
    in_bus.char_code <= ch;
    in_bus.ends_word <= ew;
    do @(posedge clk); while (!in_bus.ready);
    r = keyer_step(cmd, ch, ew);
    pending_levels.push_back(typed ? typed_res : r);
  endtask

  // Stop offering and wait for every expected beat
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_unit_ticks(logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_wdata      <= value;
    key_unit_ticks  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, and a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_on) begin
        out_bus.ready <= ($urandom_range(99) >= 24);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin : level_check
    level_beat_t got;
    level_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.led_on, out_bus.busy_res, out_bus.accepted, out_bus.bad_char};
      if (pending_levels.size() == 0) begin
        level_errors++;
        if (level_errors <= 10)
          $display("%0t: unexpected beat led=%0b busy=%0b acc=%0b bad=%0b", $realtime,
                   got.led_on, got.busy_res, got.accepted, got.bad_char);
      end else begin
        want = pending_levels.pop_front();
        if (got.led_on !== want.led_on || got.busy_res !== want.busy_res ||
            got.accepted !== want.accepted || got.bad_char !== want.bad_char) begin
          level_errors++;
          if (level_errors <= 10)
            $display("%0t: mismatch exp led=%0b busy=%0b acc=%0b bad=%0b, got %0b %0b %0b %0b",
                     $realtime, want.led_on, want.busy_res, want.accepted, want.bad_char,
                     got.led_on, got.busy_res, got.accepted, got.bad_char);
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          row;
    int          k;
    int          phase_idx;
    int          phase_beats;
    int          span;
    logic [7:0]  ch;
    logic [16:0] unit_eff;
    bit          held;
    bit          paused;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = CMD_TICK;
    in_bus.char_code = 8'h00;
    in_bus.ends_word = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 16'h0000;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (row = 0; row < 25; row++) begin
      if (plan[row].kind == ROW_UNIT) begin
        write_unit_ticks(plan[row].unit);
      end else begin
        for (k = 0; k < plan[row].reps; k++)
          drive_beat(plan[row].cmd, plan[row].ch, plan[row].ew, plan[row].typed,
                     plan[row].res);
      end
    end

    // Random letters: an offer, then a run of ticks with stray offers mixed in
    for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
      write_unit_ticks(phase_unit[phase_idx]);
      idle_on     = (phase_idx != 1);
      unit_eff    = (phase_unit[phase_idx] == 16'd0) ? 17'd1 : {1'b0, phase_unit[phase_idx]};
      phase_beats = 0;
      held        = 1'b0;
      paused      = 1'b0;
      while (phase_beats < PHASE_BEATS) begin
        if (phase_idx == 2 && !held && phase_beats >= 100) begin
          hold_request = 1'b1;
          held         = 1'b1;
        end
        if (phase_idx == 3 && !paused && phase_beats >= 150) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 8) begin
          case ($urandom_range(3))
            0:       ch = 8'("A" + $urandom_range(25));
            1:       ch = 8'("a" + $urandom_range(25));
            2:       ch = 8'("0" + $urandom_range(9));
            default: ch = $urandom_range(1) ? 8'(",") : 8'(".");
          endcase
        end else begin
          ch = 8'($urandom_range(255));
        end
        drive_beat(CMD_OFFER, ch, 1'($urandom_range(1)), 1'b0, '0);
        phase_beats++;
        span = $urandom_range(4, 36) * int'(unit_eff);
        for (k = 0; k < span; k++) begin
          if ($urandom_range(19) == 0) begin
            drive_beat(CMD_OFFER, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
          end else begin
            drive_beat(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            phase_beats++;
          end
        end
      end
    end
    idle_on = 1'b1;

    drain_results();
    repeat (8) @(posedge clk);
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
